// ===== rtl/vdlt_pkg.sv =====
// Shared constants and types for the dot/line timing core.
package vdlt_pkg;

    localparam int unsigned DotW  = 9;
    localparam int unsigned LineW = 8;
    localparam int unsigned RegW  = 8;

    localparam logic [DotW-1:0]  DotsPerLine     = 9'd456;
    localparam logic [LineW-1:0] LinesPerFrame   = 8'd154;
    localparam logic [LineW-1:0] FirstVblankLine = 8'd144;
    localparam logic [LineW-1:0] LastLine        = 8'd153;
    localparam logic [DotW-1:0]  ScanEndDot      = 9'd80;
    localparam logic [DotW-1:0]  DrawEndDot      = 9'd252;
    // 256 - 80: adding this in 8 bits subtracts the scan length mod 256
    localparam logic [RegW-1:0]  ScanEndNeg      = 8'd176;

    // display modes as reported on the mode field
    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_DRAW   = 2'd3
    } t_mode;

    // register indexes of the configuration port
    typedef enum logic [1:0] {
        REG_SCROLL_X     = 2'd0,
        REG_SCROLL_Y     = 2'd1,
        REG_LINE_COMPARE = 2'd2,
        REG_UNUSED       = 2'd3
    } t_reg_idx;

    // opcodes of the input beat
    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

endpackage

// ===== rtl/video_dot_line_timing_core.sv =====
// Dot/line timing core: counters, mode decode and background fetch offsets.
//
// Each accepted beat either advances the dot counter by one or loads the line
// counter, and produces exactly one result beat in the next cycle, holding the
// updated dot and line, the display mode, the line-compare match and the
// scrolled tile-map and tile-data row offsets. The core takes one beat per
// clock: the counter update and the offset arithmetic sit between the counter
// registers and a single result register. The input stalls only while that
// result register holds a beat that downstream has not yet taken. Configuration
// writes (scroll and line compare) are applied at the edge where the write
// enable is high and affect the results of later beats.
module video_dot_line_timing_core
    import vdlt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [RegW-1:0]      i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_in_opcode,
    input  logic [LineW-1:0]     i_in_new_line,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [DotW-1:0]      o_out_dot_x,
    output logic [LineW-1:0]     o_out_line_y,
    output logic [1:0]           o_out_mode,
    output logic                 o_out_compare_match,
    output logic [9:0]           o_out_map_offset,
    output logic [3:0]           o_out_data_low_offset,
    output logic [3:0]           o_out_data_high_offset
);

    logic [DotW-1:0]  r_dot,  n_dot;
    logic [LineW-1:0] r_line, n_line;
    logic [RegW-1:0]  r_scx, r_scy, r_lyc;

    logic             r_out_valid;
    logic [DotW-1:0]  r_dot_x;
    logic [LineW-1:0] r_line_y;
    t_mode            r_mode, n_mode;
    logic             r_match;
    logic [9:0]       r_map, n_map;
    logic [3:0]       r_low, n_low;

    logic             in_take;
    logic [DotW-1:0]  dot_inc;
    logic [LineW-1:0] line_inc;
    logic [RegW-1:0]  col_sum, row_sum;

    // hold the input while an untaken result sits in the output register
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_take    = i_in_valid & ~o_in_stall;

    // advance the dot, step the line on wrap, or load a clamped line
    always_comb begin
        dot_inc  = r_dot + 9'd1;
        line_inc = r_line + 8'd1;
        n_dot    = r_dot;
        n_line   = r_line;
        if (i_in_opcode == OP_ADVANCE) begin
            if (dot_inc >= DotsPerLine) begin
                n_dot  = '0;
                n_line = (line_inc >= LinesPerFrame) ? '0 : line_inc;
            end else begin
                n_dot  = dot_inc;
            end
        end else begin
            n_line = (i_in_new_line > LastLine) ? LastLine : i_in_new_line;
        end
    end

    // decode mode and scrolled fetch offsets from the updated position
    always_comb begin
        if (n_line >= FirstVblankLine) begin
            n_mode = MODE_VBLANK;
        end else if (n_dot < ScanEndDot) begin
            n_mode = MODE_OAM;
        end else if (n_dot < DrawEndDot) begin
            n_mode = MODE_DRAW;
        end else begin
            n_mode = MODE_HBLANK;
        end
        col_sum = r_scx + n_dot[RegW-1:0] + ScanEndNeg;
        row_sum = r_scy + n_line;
        n_map   = {row_sum[7:3], col_sum[7:3]};
        n_low   = {row_sum[2:0], 1'b0};
    end

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scx <= '0;
            r_scy <= '0;
            r_lyc <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SCROLL_X:     r_scx <= i_cfg_data;
                REG_SCROLL_Y:     r_scy <= i_cfg_data;
                REG_LINE_COMPARE: r_lyc <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // advance counters on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot  <= '0;
            r_line <= '0;
        end else if (in_take) begin
            r_dot  <= n_dot;
            r_line <= n_line;
        end
    end

    // load the result register; drop valid once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_dot_x  <= n_dot;
            r_line_y <= n_line;
            r_mode   <= n_mode;
            r_match  <= (n_line == r_lyc);
            r_map    <= n_map;
            r_low    <= n_low;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_out_dot_x            = r_dot_x;
    assign o_out_line_y           = r_line_y;
    assign o_out_mode             = r_mode;
    assign o_out_compare_match    = r_match;
    assign o_out_map_offset       = r_map;
    assign o_out_data_low_offset  = r_low;
    assign o_out_data_high_offset = {r_low[3:1], 1'b1};

endmodule

// ===== rtl/vdlt_chk.sv =====
// Port-level checks for the dot/line timing core and their bind.
module vdlt_chk
    import vdlt_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [DotW-1:0]  o_out_dot_x,
    input logic [LineW-1:0] o_out_line_y,
    input logic [1:0]       o_out_mode
);

    // a stalled result beat keeps its position
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_dot_x) && $stable(o_out_line_y))
        else $error("result beat changed while stalled");

    // the input stalls only behind an untaken result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a pending result");

    // reported position stays inside the frame
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_dot_x < DotsPerLine && o_out_line_y < LinesPerFrame)
        else $error("position outside frame");

    // vblank lines always report vblank
    a_vblank_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_line_y >= FirstVblankLine |-> o_out_mode == MODE_VBLANK)
        else $error("vblank line reports wrong mode");

    // an accepted beat always yields a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted beat produced no result");

endmodule

bind video_dot_line_timing_core vdlt_chk u_vdlt_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_out_dot_x  (o_out_dot_x),
    .o_out_line_y (o_out_line_y),
    .o_out_mode   (o_out_mode)
);

// ===== tb/tb.sv =====
// Self-checking bench for the dot/line timing core with a scoreboard class.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vdlt_pkg::*;

    // one result beat as the core reports it
    typedef struct packed {
        logic [DotW-1:0]  dot_x;
        logic [LineW-1:0] line_y;
        t_mode            mode;
        logic             compare_match;
        logic [9:0]       map_offset;
        logic [3:0]       data_low_offset;
        logic [3:0]       data_high_offset;
    } t_timing_beat;

    // Tracks the dot and line counters and the registers, and holds the
    // timing beats still owed by the core.
    class t_line_timing_scoreboard;
        logic [DotW-1:0]  dot_cnt;
        logic [LineW-1:0] line_cnt;
        logic [RegW-1:0]  scroll_x;
        logic [RegW-1:0]  scroll_y;
        logic [RegW-1:0]  line_cmp;
        t_timing_beat     owed_q[$];
        int unsigned      errors;

        function new();
            dot_cnt  = '0;
            line_cnt = '0;
            scroll_x = '0;
            scroll_y = '0;
            line_cmp = '0;
            errors   = 0;
        endfunction

        // mirror a register write; the spare index holds nothing
        function void write_reg(t_reg_idx idx, logic [RegW-1:0] val);
            case (idx)
                REG_SCROLL_X:     scroll_x = val;
                REG_SCROLL_Y:     scroll_y = val;
                REG_LINE_COMPARE: line_cmp = val;
                default: ;
            endcase
        endfunction

        function int unsigned owed();
            return owed_q.size();
        endfunction

        // step the counters for an accepted input beat and queue its timing beat
        function void note_beat(logic op, logic [LineW-1:0] nl);
            t_timing_beat t;
            int col;
            int row;
            int fine;
            if (op == OP_ADVANCE) begin
                if (dot_cnt >= DotsPerLine - 1) begin
                    dot_cnt  = '0;
                    line_cnt = (line_cnt >= LinesPerFrame - 1) ? '0 : line_cnt + 1'b1;
                end else begin
                    dot_cnt = dot_cnt + 1'b1;
                end
            end else begin
                line_cnt = (nl > LastLine) ? LastLine : nl;
            end
            // horizontal term wraps mod 256 even before the scan ends
            col  = ((int'(scroll_x) + int'(dot_cnt) + 256 - int'(ScanEndDot)) % 256) / 8;
            row  = ((int'(scroll_y) + int'(line_cnt)) % 256) / 8;
            fine = (int'(scroll_y) + int'(line_cnt)) % 8;
            t.dot_x  = dot_cnt;
            t.line_y = line_cnt;
            if (line_cnt >= FirstVblankLine)
                t.mode = MODE_VBLANK;
            else if (dot_cnt < ScanEndDot)
                t.mode = MODE_OAM;
            else if (dot_cnt < DrawEndDot)
                t.mode = MODE_DRAW;
            else
                t.mode = MODE_HBLANK;
            t.compare_match    = (line_cnt == line_cmp);
            t.map_offset       = 10'(col + 32 * row);
            t.data_low_offset  = 4'(2 * fine);
            t.data_high_offset = 4'(2 * fine + 1);
            owed_q.push_back(t);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // compare a result beat against the oldest owed one
        function void check_beat(t_timing_beat got);
            t_timing_beat want;
            if (owed_q.size() == 0) begin
                $error("unexpected result beat: dot_x %0d line_y %0d", got.dot_x, got.line_y);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            check_field("dot_x", want.dot_x, got.dot_x);
            check_field("line_y", want.line_y, got.line_y);
            check_field("mode", want.mode, got.mode);
            check_field("compare_match", want.compare_match, got.compare_match);
            check_field("map_offset", want.map_offset, got.map_offset);
            check_field("data_low_offset", want.data_low_offset, got.data_low_offset);
            check_field("data_high_offset", want.data_high_offset, got.data_high_offset);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_index;
    logic [RegW-1:0]   i_cfg_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_in_opcode;
    logic [LineW-1:0]  i_in_new_line;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [DotW-1:0]   o_out_dot_x;
    logic [LineW-1:0]  o_out_line_y;
    logic [1:0]        o_out_mode;
    logic              o_out_compare_match;
    logic [9:0]        o_out_map_offset;
    logic [3:0]        o_out_data_low_offset;
    logic [3:0]        o_out_data_high_offset;

    t_line_timing_scoreboard sb;
    int unsigned             beats_in;
    bit                      calm;

    video_dot_line_timing_core i_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_in_opcode            (i_in_opcode),
        .i_in_new_line          (i_in_new_line),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_out_dot_x            (o_out_dot_x),
        .o_out_line_y           (o_out_line_y),
        .o_out_mode             (o_out_mode),
        .o_out_compare_match    (o_out_compare_match),
        .o_out_map_offset       (o_out_map_offset),
        .o_out_data_low_offset  (o_out_data_low_offset),
        .o_out_data_high_offset (o_out_data_high_offset)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // stall the result side at random unless in a calm phase
    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 38);
    end

    // sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        t_timing_beat seen;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                seen.dot_x            = o_out_dot_x;
                seen.line_y           = o_out_line_y;
                seen.mode             = t_mode'(o_out_mode);
                seen.compare_match    = o_out_compare_match;
                seen.map_offset       = o_out_map_offset;
                seen.data_low_offset  = o_out_data_low_offset;
                seen.data_high_offset = o_out_data_high_offset;
                sb.check_beat(seen);
            end
            if (i_in_valid && !o_in_stall) begin
                sb.note_beat(i_in_opcode, i_in_new_line);
                beats_in++;
            end
        end
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 38);
    endfunction

    // offer one input beat and hold it until it is taken
    task automatic push_beat(logic op, logic [LineW-1:0] nl);
        int unsigned target;
        while (take_break()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_opcode   <= op;
        i_in_new_line <= nl;
        target = beats_in + 1;
        do @(negedge i_clk); while (beats_in != target);
    endtask

    // drop valid and wait until every owed beat is back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.owed() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [RegW-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [RegW-1:0] pick_reg();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom());
        endcase
    endfunction

    // random beats, mostly advances; loads lean toward the line boundaries
    task automatic run_phase(int unsigned n_beats);
        logic [LineW-1:0] nl;
        logic             op;
        for (int unsigned i = 0; i < n_beats; i++) begin
            op = ($urandom_range(0, 99) < 85) ? OP_ADVANCE : OP_LOAD;
            nl = 8'($urandom());
            if (op == OP_LOAD) begin
                case ($urandom_range(0, 7))
                    0: nl = FirstVblankLine - 1'b1;
                    1: nl = FirstVblankLine;
                    2: nl = LastLine;
                    3: nl = LastLine + 1'b1;
                    4: nl = sb.line_cmp;
                    default: ;
                endcase
            end
            push_beat(op, nl);
        end
    endtask

    initial begin
        sb          = new();
        beats_in    = 0;
        calm        = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_SCROLL_X;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_opcode = OP_ADVANCE;
        i_in_new_line = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset registers, then line loads around the limits
        push_beat(OP_ADVANCE, 8'h00);
        push_beat(OP_LOAD, 8'd0);
        push_beat(OP_LOAD, LastLine);
        push_beat(OP_LOAD, LastLine + 1'b1);
        push_beat(OP_LOAD, 8'hff);
        push_beat(OP_LOAD, FirstVblankLine - 1'b1);
        push_beat(OP_LOAD, FirstVblankLine);
        push_beat(OP_ADVANCE, 8'hff);
        settle();
        write_reg(REG_SCROLL_X, 8'hff);
        write_reg(REG_SCROLL_Y, 8'hff);
        write_reg(REG_LINE_COMPARE, LastLine);
        push_beat(OP_LOAD, LastLine);
        push_beat(OP_ADVANCE, 8'h00);
        push_beat(OP_ADVANCE, 8'h55);
        push_beat(OP_LOAD, 8'd0);
        settle();
        // the spare index must leave every register alone
        write_reg(REG_UNUSED, 8'h00);
        write_reg(REG_UNUSED, 8'hff);
        push_beat(OP_ADVANCE, 8'haa);
        push_beat(OP_LOAD, 8'd7);

        // random phases with fresh register settings each time
        for (int p = 0; p < 6; p++) begin
            settle();
            calm = (p == 2) || (p == 3);
            write_reg(REG_SCROLL_X, (p == 0) ? 8'h00 : (p == 1) ? 8'hff : pick_reg());
            write_reg(REG_SCROLL_Y, (p == 0) ? 8'h00 : (p == 1) ? 8'hff : pick_reg());
            write_reg(REG_LINE_COMPARE,
                      (p == 0) ? 8'h00 : (p == 1) ? 8'hff : 8'($urandom_range(0, 160)));
            write_reg(REG_UNUSED, 8'($urandom()));
            run_phase(20);
            if (p == 3) begin
                // advance from the last line until the dot wraps to force both wraps
                push_beat(OP_LOAD, LastLine);
                do push_beat(OP_ADVANCE, 8'($urandom())); while (sb.dot_cnt != '0);
            end
        end

        // drain and give late beats a chance to show up
        calm = 1'b0;
        i_in_valid <= 1'b0;
        while (sb.owed() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        if (sb.errors == 0 && sb.owed() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/vdlt_pkg.sv
rtl/video_dot_line_timing_core.sv
rtl/vdlt_chk.sv
tb/tb.sv
